// File: hdl/rgbhd_pkg.sv
// Shared types and constants for the RGB 2x2 box-filter half-size downscaler.
// Used by the line store memory and the top level; depends on nothing.
package rgbhd_pkg;

	localparam int REG_W = 13;
	localparam int HEIGHT_W = 13;
	localparam int ROW_W = 12;
	localparam int HEIGHT_LIMIT = 4096;

	localparam logic [REG_W-1:0] WIDTH_RESET = 13'd640;
	localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd480;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 1'b1;

	typedef struct packed {
		logic [8:0] blue;
		logic [8:0] green;
		logic [8:0] red;
	} pair_sum_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		logic       frame_last;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} out_pix_t;

endpackage

// File: hdl/rgbhd_line_mem.sv
// Single-port line store for the horizontal pair sums of even source rows.
// Synchronous write and registered read; uses the pair_sum_t type from rgbhd_pkg.
module rgbhd_line_mem import rgbhd_pkg::*; #(
	parameter int DEPTH = 2048,
	parameter int ADDR_W = 11
) (
	input  logic              clk,
	input  logic              acc_en,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] addr,
	input  pair_sum_t         wdata,
	output pair_sum_t         rdata
);

	pair_sum_t mem [DEPTH];
	pair_sum_t rdata_q;

	always_ff @(posedge clk) begin
		if (acc_en && wr_en) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_en && !wr_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/rgb_half_downscale_box2x2_top.sv
// Top level of the RGB888 2x2 box-filter half-size downscaler.
// Depends on rgbhd_pkg and rgbhd_line_mem.

// The block takes one source pixel per clock in raster order and gives one pixel for
// every 2x2 block, each channel the truncated mean of four samples. A result is formed
// from the first-stage registers loaded when the bottom-right pixel of its block is
// taken, then moves into the output buffer. The pair sums of even
// rows sit in a single-port line store of MAX_WIDTH/2 entries; each pixel makes at
// most one access to it, so the store never limits the rate of one pixel per clock.
// The store needs no clearing pass after reset. A two-entry output buffer lets input
// keep flowing while a result waits; input stalls only once both entries are full.
// Width and height must be written only between frames; the block does not enforce this.
module rgb_half_downscale_box2x2_top import rgbhd_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           red_in,
	input  logic [7:0]           green_in,
	input  logic [7:0]           blue_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           red_out,
	output logic [7:0]           green_out,
	output logic [7:0]           blue_out,
	output logic                 frame_last
);

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int SLOT_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int COL_W = ($clog2(MAX_WIDTH) > SLOT_W) ? $clog2(MAX_WIDTH) : SLOT_W + 1;
	localparam int WID_W = $clog2(MAX_WIDTH + 1);

	logic [REG_W-1:0] src_width_q;
	logic [REG_W-1:0] src_height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	pixel_t           left_q;

	logic [WID_W-1:0]    w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic [WID_W-1:0]    out_w_m1;
	logic [HEIGHT_W-1:0] out_h_m1;
	logic                in_accept;
	logic                pipe_en;
	logic                have_pair;
	logic                row_live;
	logic                mem_acc;
	logic                mem_wr;
	logic                emit;
	logic                last_col;
	logic                last_row;
	logic                self_above;
	logic                is_last;
	pixel_t              pix;
	pair_sum_t           pair;
	pair_sum_t           rd_data;

	logic      valid_s1;
	logic      emit_s1;
	logic      self_s1;
	logic      last_s1;
	pair_sum_t pair_s1;

	pair_sum_t above;
	out_pix_t  res;
	out_pix_t  out_q;
	out_pix_t  skid_q;
	logic      out_valid_q;
	logic      skid_valid_q;
	logic      push;
	logic      out_take;
	logic      main_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q <= WIDTH_RESET;
			src_height_q <= HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SRC_WIDTH: src_width_q <= cfg_data;
				CFG_SRC_HEIGHT: src_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (src_width_q == '0) begin
			w_eff = WID_W'(1);
		end else if (32'(src_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WID_W'(MAX_WIDTH);
		end else begin
			w_eff = WID_W'(src_width_q);
		end
		if (src_height_q == '0) begin
			h_eff = HEIGHT_W'(1);
		end else if (32'(src_height_q) > 32'(HEIGHT_LIMIT)) begin
			h_eff = HEIGHT_W'(HEIGHT_LIMIT);
		end else begin
			h_eff = src_height_q;
		end
		out_w_m1 = (w_eff[WID_W-1:1] == '0) ? '0 : (WID_W'(w_eff[WID_W-1:1]) - WID_W'(1));
		out_h_m1 = (h_eff[HEIGHT_W-1:1] == '0) ? '0 :
			(HEIGHT_W'(h_eff[HEIGHT_W-1:1]) - HEIGHT_W'(1));
	end

	assign pipe_en = !skid_valid_q;
	assign in_stall = skid_valid_q;
	assign in_accept = in_valid && pipe_en;
	assign pix = '{blue: blue_in, green: green_in, red: red_in};

	always_comb begin
		pair = '{blue: 9'(left_q.blue) + 9'(pix.blue),
			green: 9'(left_q.green) + 9'(pix.green),
			red: 9'(left_q.red) + 9'(pix.red)};
		if (w_eff == WID_W'(1)) begin
			have_pair = (col_q == '0);
			pair = '{blue: {pix.blue, 1'b0}, green: {pix.green, 1'b0}, red: {pix.red, 1'b0}};
		end else begin
			have_pair = (32'(col_q) < 32'({w_eff[WID_W-1:1], 1'b0})) && col_q[0];
		end
		row_live = 32'(row_q) < 32'({h_eff[HEIGHT_W-1:1], 1'b0});
		self_above = (h_eff == HEIGHT_W'(1));
		mem_acc = in_accept && have_pair && !self_above && row_live;
		mem_wr = !row_q[0];
		emit = have_pair && (self_above ? (row_q == '0) : (row_live && row_q[0]));
		last_col = (32'(col_q) + 32'd1 >= 32'(w_eff));
		last_row = (32'(row_q) + 32'd1 >= 32'(h_eff));
		is_last = (32'(col_q[COL_W-1:1]) == 32'(out_w_m1)) &&
			(32'(row_q[ROW_W-1:1]) == 32'(out_h_m1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			left_q <= '0;
		end else if (in_accept) begin
			if (w_eff != WID_W'(1) && !col_q[0] &&
				32'(col_q) < 32'({w_eff[WID_W-1:1], 1'b0})) begin
				left_q <= pix;
			end
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	rgbhd_line_mem #(
		.DEPTH(LINE_DEPTH),
		.ADDR_W(SLOT_W)
	) u_line_mem (
		.clk(clk),
		.acc_en(mem_acc),
		.wr_en(mem_wr),
		.addr(col_q[SLOT_W:1]),
		.wdata(pair),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pipe_en) begin
			valid_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			emit_s1 <= emit;
			self_s1 <= self_above;
			last_s1 <= is_last;
			pair_s1 <= pair;
		end
	end

	always_comb begin
		above = self_s1 ? pair_s1 : rd_data;
		res.red = 8'((10'(pair_s1.red) + 10'(above.red)) >> 2);
		res.green = 8'((10'(pair_s1.green) + 10'(above.green)) >> 2);
		res.blue = 8'((10'(pair_s1.blue) + 10'(above.blue)) >> 2);
		res.frame_last = last_s1;
	end

	assign push = valid_s1 && emit_s1 && pipe_en;
	assign out_take = out_valid_q && !out_stall;
	assign main_free = !out_valid_q || out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			out_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out = out_q.red;
	assign green_out = out_q.green;
	assign blue_out = out_q.blue;
	assign frame_last = out_q.frame_last;

	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register is empty");

	a_accept_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> valid_s1)
		else $error("accepted item missing from first stage");

	a_read_data_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !pipe_en) |=> $stable(rd_data))
		else $error("line store read data changed while first stage was held");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(MAX_WIDTH))
		else $error("column counter beyond maximum width");

endmodule
